>>> rtl/mpfs_pkg.sv
package mpfs_pkg;

   // default display geometry
   localparam int DEF_COLUMNS = 128;
   localparam int DEF_ROWS    = 64;

   // scan stream command bytes
   localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
   localparam logic [7:0] CMD_COL_LOW    = 8'h00;
   localparam logic [7:0] COL_HIGH_RESET = 8'h10;  // 0x10 or 0x12 depending on panel

   // slots of a page: three commands, then one data byte per column
   localparam int SLOT_PAGE_CMD = 0;
   localparam int SLOT_COL_LOW  = 1;
   localparam int SLOT_COL_HIGH = 2;
   localparam int HEAD_SLOTS    = 3;

   // config port
   localparam int         CSR_AW           = 3;
   localparam int         CSR_DW           = 32;
   localparam logic [0:0] CSR_IDX_COL_HIGH = 1'b0;

   typedef enum logic [1:0] {
      OP_DRAW = 2'd0,
      OP_FILL = 2'd1,
      OP_ARM  = 2'd2,
      OP_EMIT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] x_first;
      logic [7:0] y_first;
      logic [7:0] x_last;
      logic [7:0] y_last;
      logic       dot_on;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic load_draw;
      logic arm;
      logic emit;
      logic fill_rd;
      logic fill_wr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic draw_empty;
      logic fill_last;
      logic scan_armed;
   } ctrl_status_type;

endpackage

>>> rtl/mpfs_ctrl.sv
module mpfs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  mpfs_pkg::op_type         req_op,
   input  mpfs_pkg::ctrl_status_type status,
   output mpfs_pkg::ctrl_cmd_type   cmd,
   output logic                     busy
);
   import mpfs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && (req_op == OP_DRAW || req_op == OP_FILL) && !status.draw_empty) begin
               state_in = ST_FILL_RD;
            end
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            if (status.fill_last) state_in = ST_IDLE;
            else                  state_in = ST_FILL_RD;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_op)
                  OP_DRAW: begin
                     cmd.load_draw = !status.draw_empty;
                  end
                  OP_FILL: begin
                     cmd.load_draw = !status.draw_empty;
                     cmd.arm       = 1'b1;
                  end
                  OP_ARM: begin
                     cmd.arm = 1'b1;
                  end
                  OP_EMIT: begin
                     cmd.emit = status.scan_armed;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL_RD: begin
            cmd.fill_rd = 1'b1;
         end
         ST_FILL_WR: begin
            cmd.fill_wr = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> rtl/mpfs_datapath.sv
module mpfs_datapath #(
   parameter int COLUMNS = mpfs_pkg::DEF_COLUMNS,
   parameter int ROWS    = mpfs_pkg::DEF_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mpfs_pkg::req_type             req_data,
   input  mpfs_pkg::ctrl_cmd_type        cmd,
   output mpfs_pkg::ctrl_status_type     status,
   output logic                          rsp_valid,
   output mpfs_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mpfs_pkg::CSR_AW-1:0]   paddr,
   input  logic [mpfs_pkg::CSR_DW-1:0]   pwdata,
   output logic [mpfs_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import mpfs_pkg::*;

   localparam int XW         = $clog2(COLUMNS);
   localparam int AW         = XW + 3;
   localparam int DEPTH      = COLUMNS * 8;
   localparam int SW         = $clog2(COLUMNS + HEAD_SLOTS);
   localparam int SCAN_PAGES = ROWS / 8;

   localparam logic [7:0]    X_MAX     = 8'(COLUMNS - 1);
   localparam logic [7:0]    Y_MAX     = 8'(ROWS - 1);
   localparam logic [SW-1:0] SLOT_LAST = SW'(COLUMNS + HEAD_SLOTS - 1);
   localparam logic [2:0]    PAGE_LAST = 3'(SCAN_PAGES - 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

   // config register
   logic [7:0] col_high_ff;
   logic       csr_hit;

   assign csr_hit = (paddr[CSR_AW-1] == CSR_IDX_COL_HIGH);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? {{(CSR_DW-8){1'b0}}, col_high_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_high_ff <= COL_HIGH_RESET;
      end else if (psel && penable && pwrite && csr_hit) begin
         col_high_ff <= pwdata[7:0];
      end
   end

   // clearing pass
   logic [AW-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_addr_ff <= clear_addr_ff + AW'(1);
      end
   end

   assign status.clear_last = (clear_addr_ff == ADDR_LAST);

   // draw / fill walker: one byte of one column per read-modify-write
   logic [7:0] x_end;
   logic [7:0] y_end;
   logic [7:0] x_clip;
   logic [7:0] y_clip;
   logic [7:0] cur_x_ff;
   logic [7:0] x_last_ff;
   logic [2:0] cur_k_ff;
   logic [5:0] y_first_ff;
   logic [5:0] y_last_ff;
   logic       dot_ff;
   logic       k_first;
   logic       k_last;
   logic [2:0] lo_off;
   logic [2:0] hi_off;
   logic [7:0] fill_mask;
   logic [AW-1:0] fill_addr;

   // a pixel draw is a one-pixel rectangle at its own corner
   assign x_end  = (req_data.op == OP_DRAW) ? req_data.x_first : req_data.x_last;
   assign y_end  = (req_data.op == OP_DRAW) ? req_data.y_first : req_data.y_last;
   assign x_clip = (x_end > X_MAX) ? X_MAX : x_end;
   assign y_clip = (y_end > Y_MAX) ? Y_MAX : y_end;
   assign status.draw_empty = (req_data.x_first > x_clip) || (req_data.y_first > y_clip);

   assign k_first   = (cur_k_ff == y_first_ff[5:3]);
   assign k_last    = (cur_k_ff == y_last_ff[5:3]);
   assign lo_off    = k_first ? y_first_ff[2:0] : 3'd0;
   assign hi_off    = k_last ? y_last_ff[2:0] : 3'd7;
   assign fill_mask = (8'hFF >> lo_off) & (8'hFF << (3'd7 - hi_off));
   assign fill_addr = {cur_x_ff[XW-1:0], ~cur_k_ff};   // page = 7 - y/8
   assign status.fill_last = k_last && (cur_x_ff == x_last_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_draw) begin
         cur_x_ff   <= req_data.x_first;
         x_last_ff  <= x_clip;
         y_first_ff <= req_data.y_first[5:0];
         y_last_ff  <= y_clip[5:0];
         cur_k_ff   <= req_data.y_first[5:3];
         dot_ff     <= req_data.dot_on;
      end else if (cmd.fill_wr && !status.fill_last) begin
         if (k_last) begin
            cur_k_ff <= y_first_ff[5:3];
            cur_x_ff <= cur_x_ff + 8'd1;
         end else begin
            cur_k_ff <= cur_k_ff + 3'd1;
         end
      end
   end

   // scan position
   logic          armed_ff;
   logic [2:0]    page_ff;
   logic [SW-1:0] slot_ff;
   logic [SW-1:0] col_wide;
   logic [AW-1:0] scan_addr;

   assign col_wide  = slot_ff - SW'(HEAD_SLOTS);
   assign scan_addr = {col_wide[XW-1:0], page_ff};
   assign status.scan_armed = armed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         page_ff  <= '0;
         slot_ff  <= '0;
      end else if (cmd.arm) begin
         armed_ff <= 1'b1;
         page_ff  <= '0;
         slot_ff  <= '0;
      end else if (cmd.emit) begin
         if (slot_ff == SLOT_LAST) begin
            slot_ff <= '0;
            if (page_ff == PAGE_LAST) begin
               armed_ff <= 1'b0;
               page_ff  <= '0;
            end else begin
               page_ff <= page_ff + 3'd1;
            end
         end else begin
            slot_ff <= slot_ff + SW'(1);
         end
      end
   end

   // frame store, one write and one registered read per cycle
   logic [7:0]    mem [DEPTH];
   logic [7:0]    mem_q_ff;
   logic [AW-1:0] raddr;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic          we;

   assign raddr = cmd.fill_rd ? fill_addr : scan_addr;
   assign we    = cmd.clear_wr || cmd.fill_wr;
   assign waddr = cmd.clear_wr ? clear_addr_ff : fill_addr;
   assign wdata = cmd.clear_wr ? 8'h00 : ((mem_q_ff & ~fill_mask) | (dot_ff ? fill_mask : 8'h00));

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      mem_q_ff <= mem[raddr];
   end

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_cmd_ff;
   logic       rsp_is_data_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (slot_ff == SW'(SLOT_PAGE_CMD)) begin
            rsp_cmd_ff <= CMD_PAGE_BASE + {5'd0, page_ff};
         end else if (slot_ff == SW'(SLOT_COL_LOW)) begin
            rsp_cmd_ff <= CMD_COL_LOW;
         end else begin
            rsp_cmd_ff <= col_high_ff;
         end
         rsp_is_data_ff <= (slot_ff >= SW'(HEAD_SLOTS));
         rsp_last_ff    <= (slot_ff == SLOT_LAST) && (page_ff == PAGE_LAST);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.out_byte   = rsp_is_data_ff ? mem_q_ff : rsp_cmd_ff;
   assign rsp_data.is_data    = rsp_is_data_ff;
   assign rsp_data.frame_last = rsp_last_ff;

endmodule

>>> rtl/mono_page_framebuffer_scanout.sv
// Monochrome page-mode framebuffer with a byte scan-out stream. The store keeps
// one byte per column and page (COLUMNS*8 bytes, bit 7-y%8 of page 7-y/8 holds
// pixel row y). Requests enter on start while busy is low; a result, when a
// request makes one, is shown on rsp_data with rsp_valid high for exactly one
// cycle and must be taken then: there is no backpressure on the result side.
// Work per request, set by the store (one write and one registered read per
// cycle) and the read-modify-write walker:
//   - draw pixel (op 0): accepted, then, if in range, busy while its byte is read
//     and rewritten; an off-screen pixel gives no busy period.
//   - fill rectangle (op 1): accepted, then, unless the rectangle clips to nothing,
//     busy while the walker reads and rewrites each touched byte (clipped width *
//     number of 8-row bands touched). The scan is re-armed at page 0 as part of the fill.
//   - arm scan (op 2): accepted with no busy period.
//   - emit (op 3): a new emit may follow every cycle; its byte appears
//     on the cycle after acceptance. An emit with no armed scan gives nothing.
// Each page of the scan is 0xB0+page, 0x00, the column-high register, then
// COLUMNS data bytes; ROWS/8 pages make a frame and frame_last marks the very
// last data byte, after which the scan disarms.
// After reset the store is zeroed by a clearing pass over all COLUMNS*8 bytes with
// busy high; the config register can be written meanwhile.
// Config: one register at byte address 0, column_high_command (reset 0x10).
module mono_page_framebuffer_scanout #(
   parameter int COLUMNS = mpfs_pkg::DEF_COLUMNS,   // 8..256
   parameter int ROWS    = mpfs_pkg::DEF_ROWS       // 8..64
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  mpfs_pkg::req_type             req_data,
   // result channel
   output logic                          rsp_valid,
   output mpfs_pkg::rsp_type             rsp_data,
   // config port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mpfs_pkg::CSR_AW-1:0]   paddr,
   input  logic [mpfs_pkg::CSR_DW-1:0]   pwdata,
   output logic [mpfs_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import mpfs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: clearing pass, request decode, fill walk
   mpfs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // store, walker counters, scan position, result register, config register
   mpfs_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

endmodule

>>> rtl/mpfs_checker.sv
module mpfs_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mpfs_pkg::req_type req_data,
   input logic              rsp_valid,
   input mpfs_pkg::rsp_type rsp_data
);
   import mpfs_pkg::*;

   // every byte comes from an emit accepted the cycle before
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_data.op == OP_EMIT))
      else $error("result without a preceding emit request");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_last) |-> rsp_data.is_data)
      else $error("frame_last on a command byte");

   // clearing pass holds requests off right after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("not busy after reset");

   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result during a busy period");

endmodule

bind mono_page_framebuffer_scanout mpfs_checker u_mpfs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
